/* rtl/hstep_pkg.sv */
`timescale 1ns / 1ps

package hstep_pkg;

   // Number of motors on the bank and number of home sensor bits.
   localparam int MotorCount  = 5;
   localparam int SensorCount = 5;

   // Configuration register defaults.
   localparam logic [7:0] QuarterStepsReset  = 8'd90;
   localparam logic [7:0] HalfTurnStepsReset = 8'd180;
   localparam logic [7:0] OverrunStepsReset  = 8'd10;

   // Eight-phase half-step coil table, bit3 A down to bit0 D.
   localparam logic [3:0] HalfStepTable [8] = '{
      4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h1, 4'h9
   };

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      TURN_NONE        = 2'd0,
      TURN_CW_QUARTER  = 2'd1,
      TURN_CW_HALF     = 2'd2,
      TURN_CCW_QUARTER = 2'd3
   } turn_type;

   typedef enum logic [1:0] {
      CSR_QUARTER_STEPS   = 2'd0,
      CSR_HALF_TURN_STEPS = 2'd1,
      CSR_OVERRUN_STEPS   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STAGE_IDLE    = 2'd0,
      STAGE_FIXED   = 2'd1,
      STAGE_SEARCH  = 2'd2,
      STAGE_OVERRUN = 2'd3
   } stage_type;

   typedef struct packed {
      logic [7:0] quarter_steps;
      logic [7:0] half_turn_steps;
      logic [7:0] overrun_steps;
   } cfg_type;

   typedef struct packed {
      logic                   opcode;
      logic [2:0]             face;
      logic [1:0]             turn;
      logic [SensorCount-1:0] sensors;
   } req_type;

   typedef struct packed {
      logic [3:0] coils;
      logic [2:0] motor;
      logic       busy_res;
      logic       done_res;
   } rsp_type;

endpackage

/* rtl/hstep_if.sv */
`timescale 1ns / 1ps

// Input item channel.
interface hstep_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [2:0] face;
   logic [1:0] turn;
   logic [4:0] sensors;

   modport source (output valid, output opcode, output face, output turn,
                   output sensors, input ready);
   modport sink   (input valid, input opcode, input face, input turn,
                   input sensors, output ready);
endinterface

// Result item channel.
interface hstep_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] coils;
   logic [2:0] motor;
   logic       busy_res;
   logic       done_res;

   modport source (output valid, output coils, output motor, output busy_res,
                   output done_res, input ready);
   modport sink   (input valid, input coils, input motor, input busy_res,
                   input done_res, output ready);
endinterface

// Configuration write channel.
interface hstep_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/stepper_half_step_homing_sequencer.sv */
`timescale 1ns / 1ps

// Channel  Modport  Fields                              Handshake
// req      sink     opcode, face, turn, sensors         valid/ready
// rsp      source   coils, motor, busy_res, done_res    valid/ready
// csr      sink     index, data                         valid/ready
//
// One item is taken per cycle while the result is not stalled; a tick's result
// passes through the input register and then the result register.
// A start item updates the move state and gives no result.
// Reset is synchronous and active high; it sets the registers to 90, 180, 10.
// A stalled result holds the result register; the input register still
// takes one more item, then req.ready drops until the result is taken.

module stepper_half_step_homing_sequencer (
   input logic        clock,
   input logic        reset,
   hstep_req_if.sink  req,
   hstep_rsp_if.source rsp,
   hstep_csr_if.sink  csr
);

   hstep_pkg::cfg_type cfg;
   hstep_pkg::req_type req_ff, req_in;
   logic               req_valid_ff, req_valid_in;
   hstep_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   hstep_pkg::rsp_type core_result;
   logic               core_result_valid;
   logic               advance;

   hstep_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   // The held item is processed when the result register has room.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !req_valid_ff || advance;

   hstep_core u_core (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .item         (req_ff),
      .cfg          (cfg),
      .result       (core_result),
      .result_valid (core_result_valid)
   );

   // Input register.
   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff;
      if (req.valid && req.ready) begin
         req_in.opcode  = req.opcode;
         req_in.face    = req.face;
         req_in.turn    = req.turn;
         req_in.sensors = req.sensors;
         req_valid_in   = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance && core_result_valid) begin
         rsp_in       = core_result;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.coils    = rsp_ff.coils;
   assign rsp.motor    = rsp_ff.motor;
   assign rsp.busy_res = rsp_ff.busy_res;
   assign rsp.done_res = rsp_ff.done_res;

   // Input is refused only when both registers are full and the result stalls.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> req_valid_ff && rsp_valid_ff && !rsp.ready)
      else $error("input refused without a full pipeline");

   // A new result only appears after the held item was processed.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without processing an item");

   // A held item that was not processed is still held.
   a_req_kept: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff)
      else $error("held item was dropped");

endmodule

/* rtl/hstep_csr.sv */
`timescale 1ns / 1ps

module hstep_csr (
   input  logic               clock,
   input  logic               reset,
   hstep_csr_if.sink          csr,
   output hstep_pkg::cfg_type cfg
);

   hstep_pkg::cfg_type cfg_ff;
   hstep_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr.ready = 1'b1;

   // Register decode; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (hstep_pkg::csr_index_type'(csr.index))
            hstep_pkg::CSR_QUARTER_STEPS:   cfg_in.quarter_steps   = csr.data;
            hstep_pkg::CSR_HALF_TURN_STEPS: cfg_in.half_turn_steps = csr.data;
            hstep_pkg::CSR_OVERRUN_STEPS:   cfg_in.overrun_steps   = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quarter_steps   <= hstep_pkg::QuarterStepsReset;
         cfg_ff.half_turn_steps <= hstep_pkg::HalfTurnStepsReset;
         cfg_ff.overrun_steps   <= hstep_pkg::OverrunStepsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/hstep_core.sv */
`timescale 1ns / 1ps

module hstep_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  hstep_pkg::req_type item,
   input  hstep_pkg::cfg_type cfg,
   output hstep_pkg::rsp_type result,
   output logic               result_valid
);

   hstep_pkg::stage_type stage_ff, stage_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] steps_ff, steps_in;
   logic       reverse_ff, reverse_in;
   logic [2:0] motor_ff, motor_in;

   logic       is_tick;
   logic       start_ok;
   logic       fired;
   logic [hstep_pkg::SensorCount-1:0] sensor_shift;
   logic       fixed_go;
   logic       search_entry;
   logic       over_entry;
   logic [7:0] over_count;
   logic       search_step;
   logic       over_step;
   logic       drive;
   logic       done;
   logic [2:0] table_idx;

   assign is_tick  = (item.opcode == hstep_pkg::OP_TICK);
   assign start_ok = (stage_ff == hstep_pkg::STAGE_IDLE) &&
                     (int'(item.face) < hstep_pkg::MotorCount) &&
                     (item.turn != hstep_pkg::TURN_NONE);

   // A motor without a sensor bit shifts in a zero, which reads as fired.
   assign sensor_shift = item.sensors >> motor_ff;
   assign fired        = !sensor_shift[0];

   // Which parts of the move this tick passes through.
   always_comb begin
      fixed_go     = 1'b0;
      search_entry = 1'b0;
      over_entry   = 1'b0;
      over_count   = cfg.overrun_steps;
      unique case (stage_ff)
         hstep_pkg::STAGE_IDLE: ;
         hstep_pkg::STAGE_FIXED: begin
            fixed_go     = (steps_ff != 8'd0);
            search_entry = (steps_ff == 8'd0);
         end
         hstep_pkg::STAGE_SEARCH: search_entry = 1'b1;
         hstep_pkg::STAGE_OVERRUN: begin
            over_entry = 1'b1;
            over_count = steps_ff;
         end
         default: ;
      endcase
      if (search_entry && fired) begin
         over_entry = 1'b1;
      end
   end

   assign search_step = search_entry && !fired;
   assign over_step   = over_entry && (over_count != 8'd0);
   assign drive       = fixed_go || search_step || over_step;
   assign done        = over_entry && !over_step;

   // Next state.
   always_comb begin
      stage_in   = stage_ff;
      phase_in   = phase_ff;
      steps_in   = steps_ff;
      reverse_in = reverse_ff;
      motor_in   = motor_ff;
      if (enable) begin
         if (!is_tick) begin
            if (start_ok) begin
               motor_in   = item.face;
               reverse_in = (item.turn == hstep_pkg::TURN_CCW_QUARTER);
               steps_in   = (item.turn == hstep_pkg::TURN_CW_HALF) ?
                            cfg.half_turn_steps : cfg.quarter_steps;
               phase_in   = 3'd0;
               stage_in   = hstep_pkg::STAGE_FIXED;
            end
         end else begin
            if (drive) begin
               phase_in = phase_ff + 3'd1;
            end
            if (fixed_go) begin
               steps_in = steps_ff - 8'd1;
               if (steps_ff == 8'd1) begin
                  stage_in = hstep_pkg::STAGE_SEARCH;
               end
            end else if (over_entry) begin
               if (over_step) begin
                  stage_in = hstep_pkg::STAGE_OVERRUN;
                  steps_in = over_count - 8'd1;
               end else begin
                  stage_in = hstep_pkg::STAGE_IDLE;
               end
            end else if (search_entry) begin
               stage_in = hstep_pkg::STAGE_SEARCH;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= hstep_pkg::STAGE_IDLE;
         phase_ff   <= 3'd0;
         steps_ff   <= 8'd0;
         reverse_ff <= 1'b0;
         motor_ff   <= 3'd0;
      end else begin
         stage_ff   <= stage_in;
         phase_ff   <= phase_in;
         steps_ff   <= steps_in;
         reverse_ff <= reverse_in;
         motor_ff   <= motor_in;
      end
   end

   // Outputs: counter-clockwise walks the table backwards.
   assign table_idx = reverse_ff ? ~phase_ff : phase_ff;

   always_comb begin
      result.coils    = drive ? hstep_pkg::HalfStepTable[table_idx] : 4'h0;
      result.motor    = motor_ff;
      result.busy_res = drive;
      result.done_res = done;
      result_valid    = is_tick;
   end

   // At most one step is driven per tick.
   a_one_drive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({fixed_go, search_step, over_step}))
      else $error("more than one step source active");

   // The done tick returns the sequencer to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      enable && is_tick && done |=> stage_ff == hstep_pkg::STAGE_IDLE)
      else $error("done tick did not return to idle");

   // A taken start begins at phase zero in the fixed part.
   a_start_load: assert property (@(posedge clock) disable iff (reset)
      enable && !is_tick && start_ok |=>
         stage_ff == hstep_pkg::STAGE_FIXED && phase_ff == 3'd0)
      else $error("start did not load the move");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Tracks the sequencer state, predicts the result of every tick and checks
// the results that the block returns, in order.
class coil_scoreboard;
   hstep_pkg::cfg_type   cfg;
   hstep_pkg::stage_type stage;
   logic [2:0]           phase;
   logic [7:0]           steps_left;
   logic                 reverse;
   logic [2:0]           active_motor;
   hstep_pkg::rsp_type   expected_drive_q[$];
   int                   errors;

   function new();
      cfg.quarter_steps   = 8'd90;
      cfg.half_turn_steps = 8'd180;
      cfg.overrun_steps   = 8'd10;
      stage        = hstep_pkg::STAGE_IDLE;
      phase        = 3'd0;
      steps_left   = 8'd0;
      reverse      = 1'b0;
      active_motor = 3'd0;
      errors       = 0;
   endfunction

   function int pending();
      return expected_drive_q.size();
   endfunction

   function void write_reg(hstep_pkg::csr_index_type idx, logic [7:0] value);
      case (idx)
         hstep_pkg::CSR_QUARTER_STEPS:   cfg.quarter_steps   = value;
         hstep_pkg::CSR_HALF_TURN_STEPS: cfg.half_turn_steps = value;
         hstep_pkg::CSR_OVERRUN_STEPS:   cfg.overrun_steps   = value;
         default: ;
      endcase
   endfunction

   // Coil pattern for the current phase, walking the table backwards for
   // counter-clockwise moves; the phase then moves on by one.
   function logic [3:0] step_coils();
      logic [2:0] row;
      logic [3:0] pattern;
      row = reverse ? 3'd7 - phase : phase;
      case (row)
         3'd0: pattern = 4'h8;
         3'd1: pattern = 4'hA;
         3'd2: pattern = 4'h2;
         3'd3: pattern = 4'h6;
         3'd4: pattern = 4'h4;
         3'd5: pattern = 4'h5;
         3'd6: pattern = 4'h1;
         default: pattern = 4'h9;
      endcase
      phase = phase + 3'd1;
      return pattern;
   endfunction

   // Applies one accepted item; a tick leaves its expected result behind.
   function void note_request(hstep_pkg::req_type item);
      hstep_pkg::rsp_type want;
      logic               stepped;
      logic               home;
      if (item.opcode == hstep_pkg::OP_START) begin
         if (stage == hstep_pkg::STAGE_IDLE && item.face < hstep_pkg::MotorCount &&
             item.turn != hstep_pkg::TURN_NONE) begin
            active_motor = item.face;
            reverse      = (item.turn == hstep_pkg::TURN_CCW_QUARTER);
            steps_left   = (item.turn == hstep_pkg::TURN_CW_HALF) ? cfg.half_turn_steps
                                                                  : cfg.quarter_steps;
            phase        = 3'd0;
            stage        = hstep_pkg::STAGE_FIXED;
         end
         return;
      end
      want.coils    = 4'h0;
      want.done_res = 1'b0;
      stepped       = 1'b0;

      // Fixed part of the move; an empty count falls through to the search.
      if (stage == hstep_pkg::STAGE_FIXED) begin
         if (steps_left != 8'd0) begin
            want.coils = step_coils();
            stepped    = 1'b1;
            steps_left = steps_left - 8'd1;
            if (steps_left == 8'd0) stage = hstep_pkg::STAGE_SEARCH;
         end else begin
            stage = hstep_pkg::STAGE_SEARCH;
         end
      end

      // Home search: the sensor is sampled before anything is driven.
      if (stage == hstep_pkg::STAGE_SEARCH && !stepped) begin
         home = (active_motor >= hstep_pkg::SensorCount) ||
                !item.sensors[active_motor];
         if (home) begin
            stage      = hstep_pkg::STAGE_OVERRUN;
            steps_left = cfg.overrun_steps;
         end else begin
            want.coils = step_coils();
            stepped    = 1'b1;
         end
      end

      // Overrun steps, then the all-off tick that ends the move.
      if (stage == hstep_pkg::STAGE_OVERRUN && !stepped) begin
         if (steps_left != 8'd0) begin
            want.coils = step_coils();
            stepped    = 1'b1;
            steps_left = steps_left - 8'd1;
         end else begin
            want.done_res = 1'b1;
            stage         = hstep_pkg::STAGE_IDLE;
         end
      end

      want.motor    = active_motor;
      want.busy_res = stepped;
      expected_drive_q.push_back(want);
   endfunction

   task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
   endtask

   task check_result(hstep_pkg::rsp_type got);
      hstep_pkg::rsp_type want;
      if (expected_drive_q.size() == 0) begin
         report($sformatf("unexpected result %h with no tick pending", got));
         return;
      end
      want = expected_drive_q.pop_front();
      if (got.coils !== want.coils)
         report($sformatf("coils got %h, expected %h", got.coils, want.coils));
      if (got.motor !== want.motor)
         report($sformatf("motor got %0d, expected %0d", got.motor, want.motor));
      if (got.busy_res !== want.busy_res)
         report($sformatf("busy got %b, expected %b", got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
         report($sformatf("done got %b, expected %b", got.done_res, want.done_res));
   endtask
endclass

module tb_top;

   localparam int TotalItems    = 1850;
   localparam int PhaseItems    = 150;
   localparam int SettleCycles  = 6;
   localparam int WatchdogLimit = 1000;

   logic clock;
   logic reset;
   bit   steady;
   int   items_sent;
   int   idle_cycles;

   coil_scoreboard sb = new();

   hstep_req_if req ();
   hstep_rsp_if rsp ();
   hstep_csr_if csr ();

   stepper_half_step_homing_sequencer dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: stalls at random except during the steady stretch.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= steady || ($urandom_range(0, 99) >= 22);
      end
   end

   // Watch every handshake; results are checked before the new item is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready)
            sb.check_result({rsp.coils, rsp.motor, rsp.busy_res, rsp.done_res});
         if (req.valid && req.ready)
            sb.note_request({req.opcode, req.face, req.turn, req.sensors});
         if (csr.valid && csr.ready)
            sb.write_reg(hstep_pkg::csr_index_type'(csr.index), csr.data);

         if ((rsp.valid && rsp.ready) || (req.valid && req.ready) ||
             (csr.valid && csr.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("Timeout: no handshake for %0d cycles", WatchdogLimit);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic hstep_pkg::req_type start_item(logic [2:0] face, logic [1:0] turn);
      hstep_pkg::req_type item;
      item.opcode  = hstep_pkg::OP_START;
      item.face    = face;
      item.turn    = turn;
      item.sensors = 5'($urandom_range(0, 31));
      return item;
   endfunction

   function automatic hstep_pkg::req_type tick_item(logic [4:0] sensors);
      hstep_pkg::req_type item;
      item.opcode  = hstep_pkg::OP_TICK;
      item.face    = 3'($urandom_range(0, 7));
      item.turn    = 2'($urandom_range(0, 3));
      item.sensors = sensors;
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input hstep_pkg::req_type item);
      steady = (items_sent >= 900 && items_sent < 1200);
      if (!steady && $urandom_range(0, 99) < 12) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.opcode  <= item.opcode;
      req.face    <= item.face;
      req.turn    <= item.turn;
      req.sensors <= item.sensors;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Holds the sender until every pending result is back and the input
   // pipeline has had time to empty.
   task automatic drain_results();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_config(input logic [7:0] quarter, input logic [7:0] half,
                             input logic [7:0] overrun);
      hstep_pkg::csr_index_type idx;
      logic [7:0]               value;
      for (int i = 0; i < 3; i++) begin
         idx = hstep_pkg::csr_index_type'(i);
         case (idx)
            hstep_pkg::CSR_QUARTER_STEPS:   value = quarter;
            hstep_pkg::CSR_HALF_TURN_STEPS: value = half;
            default:                        value = overrun;
         endcase
         csr.valid <= 1'b1;
         csr.index <= idx;
         csr.data  <= value;
         do @(posedge clock); while (!csr.ready);
         @(negedge clock);
      end
      csr.valid <= 1'b0;
   endtask

   // Mostly small counts, with the empty and full values now and then.
   function automatic logic [7:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return 8'd0;
      if (roll < 10) return 8'd255;
      return 8'($urandom_range(1, 12));
   endfunction

   // Finishes a move in progress, or starts and runs a new one, with some
   // ignored items mixed in.
   task automatic run_move();
      hstep_pkg::req_type item;
      logic [4:0]         sensors;
      if (sb.stage == hstep_pkg::STAGE_IDLE) begin
         if ($urandom_range(0, 99) < 12) begin
            if ($urandom_range(0, 1) == 0)
               send_item(start_item(3'($urandom_range(hstep_pkg::MotorCount, 7)),
                                    2'($urandom_range(0, 3))));
            else
               send_item(tick_item(5'($urandom_range(0, 31))));
         end
         if ($urandom_range(0, 99) < 8)
            send_item(start_item(3'($urandom_range(0, hstep_pkg::MotorCount - 1)),
                                 hstep_pkg::TURN_NONE));
         send_item(start_item(3'($urandom_range(0, hstep_pkg::MotorCount - 1)),
                              2'($urandom_range(1, 3))));
      end
      while (sb.stage != hstep_pkg::STAGE_IDLE) begin
         if ($urandom_range(0, 99) < 4) begin
            item = start_item(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
         end else begin
            sensors = 5'($urandom_range(0, 31));
            // Let the home sensor fire on about one tick in four of the search.
            if (sb.stage == hstep_pkg::STAGE_SEARCH ||
                (sb.stage == hstep_pkg::STAGE_FIXED && sb.steps_left == 8'd0))
               sensors[sb.active_motor] = ($urandom_range(0, 3) != 0);
            item = tick_item(sensors);
         end
         send_item(item);
      end
   endtask

   initial begin
      int phase_no;
      int phase_end;

      reset       = 1'b1;
      steady      = 1'b0;
      items_sent  = 0;
      idle_cycles = 0;
      req.valid   = 1'b0;
      req.opcode  = hstep_pkg::OP_TICK;
      req.face    = 3'd0;
      req.turn    = hstep_pkg::TURN_NONE;
      req.sensors = 5'h1F;
      csr.valid   = 1'b0;
      csr.index   = hstep_pkg::CSR_QUARTER_STEPS;
      csr.data    = 8'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items under the reset settings: idle ticks, rejected starts,
      // a counter-clockwise move and a start while busy.
      send_item(tick_item(5'h00));
      send_item(tick_item(5'h1F));
      send_item(start_item(3'd5, hstep_pkg::TURN_CW_QUARTER));
      send_item(start_item(3'd7, hstep_pkg::TURN_CCW_QUARTER));
      send_item(start_item(3'd2, hstep_pkg::TURN_NONE));
      send_item(tick_item(5'h00));
      send_item(start_item(3'd4, hstep_pkg::TURN_CCW_QUARTER));
      send_item(tick_item(5'h1F));
      send_item(tick_item(5'h00));
      send_item(tick_item(5'h0F));
      send_item(start_item(3'd1, hstep_pkg::TURN_CW_HALF));
      send_item(start_item(3'd0, hstep_pkg::TURN_CW_QUARTER));
      send_item(tick_item(5'h10));
      send_item(tick_item(5'h1F));

      // Random moves in phases, each phase under its own register settings.
      phase_no = 0;
      while (items_sent < TotalItems) begin
         if (phase_no > 0) begin
            drain_results();
            case (phase_no)
               1:       set_config(8'd0, 8'd1, 8'd0);
               2:       set_config(8'd255, 8'd255, 8'd255);
               default: set_config(pick_count(), pick_count(), pick_count());
            endcase
         end
         phase_end = items_sent + PhaseItems;
         do run_move(); while (items_sent < phase_end && items_sent < TotalItems);
         phase_no++;
      end

      drain_results();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* stepper_half_step_homing_sequencer.f */
rtl/hstep_pkg.sv
rtl/hstep_if.sv
rtl/hstep_csr.sv
rtl/hstep_core.sv
rtl/stepper_half_step_homing_sequencer.sv
test/tb_top.sv
